[src/spmq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// spmq_pkg: shared definitions for the strict priority message queues
// status codes, register map and default sizes
// ---------------------------------------------------------------------------
package spmq_pkg;

   // default sizes
   localparam int DEF_NUM_LEVELS  = 4;
   localparam int DEF_QUEUE_DEPTH = 10;

   // field widths
   localparam int ID_W      = 16;
   localparam int PRIO_W    = 8;
   localparam int PAYLOAD_W = 32;
   localparam int STATUS_W  = 3;
   localparam int ENTRY_W   = ID_W + PAYLOAD_W;

   // register map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 8;
   localparam int COUNT_W    = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_LEVEL_COUNT = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LEVEL_BASE  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LEVEL_LAST  = 3'd4;

   // request function codes
   localparam logic FUNC_ENQUEUE = 1'b0;
   localparam logic FUNC_SERVE   = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_QUEUED  = 3'd0,
      ST_FULL    = 3'd1,
      ST_NOMATCH = 3'd2,
      ST_SERVED  = 3'd3,
      ST_EMPTY   = 3'd4
   } status_type;

endpackage
`default_nettype wire

[src/spmq_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// spmq_ram: generic single write, single read ram
// one write port, one read port with registered, enabled read data
// ---------------------------------------------------------------------------
module spmq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 40,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[src/strict_priority_message_queues.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// strict_priority_message_queues: per-level fifos served by strict priority
// enqueue into the first matching level, serve the oldest message of the
// most urgent non-empty level
// ---------------------------------------------------------------------------
//  channel  | direction | handshake                 | contents
//  req_     | in        | req_valid / req_stall     | func, id, priority, payload
//  rsp_     | out       | rsp_valid / rsp_stall     | status, id, priority, payload
//  csr_     | in        | csr_wr_en                 | register index and data
//
//  one request per cycle while the response is not stalled, each gives one registered response
//  the message store is a ram with a registered read; a serve reads it at
//  accept and the data shows up with the response register
//  head and fill pointers live in flops, updated at accept, so a following
//  request always sees the new pointers and the ram never sees a read and a
//  write of one entry in the same cycle
//  reset clears registers, pointers and the response valid; the ram is not
//  cleared, since no entry is read before it is written
//  a stalled response holds the request channel stalled too
// ---------------------------------------------------------------------------
module strict_priority_message_queues
   import spmq_pkg::*;
#(
   parameter int NUM_LEVELS  = DEF_NUM_LEVELS,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_func,
   input  wire logic [ID_W-1:0]       req_msg_id,
   input  wire logic [PRIO_W-1:0]     req_msg_priority,
   input  wire logic [PAYLOAD_W-1:0]  req_msg_payload,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [STATUS_W-1:0]   rsp_status,
   output logic      [ID_W-1:0]       rsp_out_id,
   output logic      [PRIO_W-1:0]     rsp_out_priority,
   output logic      [PAYLOAD_W-1:0]  rsp_out_payload,
   // configuration
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int ACT_W  = $clog2(NUM_LEVELS + 1);
   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W  = PTR_W + 1;
   localparam int RAM_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
   localparam int ADDR_W = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

   // configuration registers
   logic [COUNT_W-1:0] level_count_ff;
   logic [PRIO_W-1:0]  level_val_ff [NUM_LEVELS];
   logic [CSR_ADDR_W-1:0] csr_slot;

   // queue pointers
   logic [PTR_W-1:0]  head_ff [NUM_LEVELS];
   logic [PTR_W-1:0]  head_in [NUM_LEVELS];
   logic [FILL_W-1:0] fill_ff [NUM_LEVELS];
   logic [FILL_W-1:0] fill_in [NUM_LEVELS];

   // response register
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   status_type         rsp_status_ff;
   status_type         rsp_status_in;
   logic [PRIO_W-1:0]  rsp_prio_ff;
   logic [PRIO_W-1:0]  rsp_prio_in;

   // selection
   logic [ACT_W-1:0]   active;
   logic               match_found;
   logic [LVL_W-1:0]   match_idx;
   logic               serve_found;
   logic [LVL_W-1:0]   serve_idx;
   logic [PRIO_W-1:0]  serve_val;
   logic               match_full;
   logic [SUM_W-1:0]   tail_sum;
   logic [PTR_W-1:0]   tail_pos;

   // ram ports
   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;

   logic req_accept;
   logic rsp_taken;

   assign rsp_taken  = rsp_valid_ff && !rsp_stall;
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // configuration writes, level slots past the instance size are dropped
   assign csr_slot = csr_addr - CSR_LEVEL_BASE;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_count_ff <= '0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            level_val_ff[i] <= '0;
         end
      end else if (csr_wr_en) begin
         if (csr_addr == CSR_LEVEL_COUNT) begin
            level_count_ff <= csr_wdata[COUNT_W-1:0];
         end else if (csr_addr >= CSR_LEVEL_BASE && csr_addr <= CSR_LEVEL_LAST) begin
            if (32'(csr_slot) < NUM_LEVELS) begin
               level_val_ff[csr_slot[LVL_W-1:0]] <= csr_wdata[PRIO_W-1:0];
            end
         end
      end
   end

   // number of levels in use, clipped to the instance size
   always_comb begin
      if (32'(level_count_ff) > NUM_LEVELS) begin
         active = ACT_W'(NUM_LEVELS);
      end else begin
         active = ACT_W'(level_count_ff);
      end
   end

   // enqueue target: lowest active slot with an equal value
   always_comb begin
      match_found = 1'b0;
      match_idx   = '0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (ACT_W'(i) < active && level_val_ff[i] == req_msg_priority) begin
            match_found = 1'b1;
            match_idx   = LVL_W'(i);
         end
      end
   end

   // serve target: smallest value among non-empty active levels, lower slot on ties
   always_comb begin
      serve_found = 1'b0;
      serve_idx   = '0;
      serve_val   = '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (ACT_W'(i) < active && fill_ff[i] != '0 &&
             (!serve_found || level_val_ff[i] < serve_val)) begin
            serve_found = 1'b1;
            serve_idx   = LVL_W'(i);
            serve_val   = level_val_ff[i];
         end
      end
   end

   // tail slot of the matched level, head plus fill wrapped once
   assign match_full = fill_ff[match_idx] == FILL_W'(QUEUE_DEPTH);
   assign tail_sum   = SUM_W'(head_ff[match_idx]) + SUM_W'(fill_ff[match_idx]);
   always_comb begin
      if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
         tail_pos = PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH));
      end else begin
         tail_pos = PTR_W'(tail_sum);
      end
   end

   assign ram_wr_en   = req_accept && req_func == FUNC_ENQUEUE && match_found && !match_full;
   assign ram_wr_addr = ADDR_W'(32'(match_idx) * QUEUE_DEPTH + 32'(tail_pos));
   assign ram_rd_en   = req_accept && req_func == FUNC_SERVE && serve_found;
   assign ram_rd_addr = ADDR_W'(32'(serve_idx) * QUEUE_DEPTH + 32'(head_ff[serve_idx]));

   // pointer updates
   always_comb begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
         head_in[i] = head_ff[i];
         fill_in[i] = fill_ff[i];
      end
      if (ram_wr_en) begin
         fill_in[match_idx] = fill_ff[match_idx] + FILL_W'(1);
      end
      if (ram_rd_en) begin
         fill_in[serve_idx] = fill_ff[serve_idx] - FILL_W'(1);
         if (head_ff[serve_idx] == PTR_W'(QUEUE_DEPTH - 1)) begin
            head_in[serve_idx] = '0;
         end else begin
            head_in[serve_idx] = head_ff[serve_idx] + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i] <= head_in[i];
            fill_ff[i] <= fill_in[i];
         end
      end
   end

   // response status and priority, the message fields come from the ram
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_taken;
      rsp_status_in = rsp_status_ff;
      rsp_prio_in   = rsp_prio_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         rsp_prio_in  = '0;
         if (req_func == FUNC_ENQUEUE) begin
            if (!match_found) begin
               rsp_status_in = ST_NOMATCH;
            end else if (match_full) begin
               rsp_status_in = ST_FULL;
            end else begin
               rsp_status_in = ST_QUEUED;
            end
         end else if (serve_found) begin
            rsp_status_in = ST_SERVED;
            rsp_prio_in   = serve_val;
         end else begin
            rsp_status_in = ST_EMPTY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_prio_ff   <= rsp_prio_in;
   end

   spmq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (RAM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data ({req_msg_id, req_msg_payload}),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ram read data holds until the next serve that reads the store, so it stays put under stall
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_out_id       = (rsp_status_ff == ST_SERVED) ?
                             ram_rd_data[ENTRY_W-1:PAYLOAD_W] : '0;
   assign rsp_out_payload  = (rsp_status_ff == ST_SERVED) ?
                             ram_rd_data[PAYLOAD_W-1:0] : '0;

`ifndef SYNTHESIS
   logic fill_in_range;
   always_comb begin
      fill_in_range = 1'b1;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (fill_ff[i] > FILL_W'(QUEUE_DEPTH)) begin
            fill_in_range = 1'b0;
         end
      end
   end

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_in_range)
      else $error("queue fill beyond depth");

   a_ram_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("store read and written by one request");

   a_empty_serve: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_func == FUNC_SERVE && !serve_found |=>
         rsp_valid && rsp_status == ST_EMPTY && rsp_out_id == '0)
      else $error("serve with all queues empty not reported");

   a_queued: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> rsp_valid && rsp_status == ST_QUEUED)
      else $error("stored message not reported as queued");
`endif

endmodule
`default_nettype wire
